/* design/dqip_pkg.sv */
// Shared types and helpers for the dotted-quad IPv4 parser.
package dqip_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned FIELD_W = 9;
    localparam int unsigned DOTS_W  = 3;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned PROD_W  = 12;

    localparam logic [CHAR_W-1:0]  CHAR_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0]  CHAR_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE = 8'h39;
    localparam logic [FIELD_W-1:0] FIELD_SAT = 9'd256;
    localparam logic [DOTS_W-1:0]  MAX_DOTS  = 3'd3;
    localparam logic [DOTS_W-1:0]  DOTS_OVER = 3'd4;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_DOT,
        KIND_END,
        KIND_OTHER
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [DIGIT_W-1:0]  digit;
    } t_token;

    function automatic logic [ADDR_W-1:0] byte_swap(input logic [ADDR_W-1:0] v);
        byte_swap = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

/* design/dqip_front.sv */
// Front end: classifies each incoming character into a parse token.
module dqip_front import dqip_pkg::*; (
    input  logic              i_push,
    input  logic              i_full,
    input  logic [CHAR_W-1:0] i_character,
    output logic              o_wr,
    output t_token            o_token
);

    logic [CHAR_W-1:0] digit_off;

    assign digit_off = i_character - CHAR_ZERO;
    assign o_wr      = i_push && !i_full;

    always_comb begin
        o_token.digit = digit_off[DIGIT_W-1:0];
        priority if (i_character == CHAR_NUL) begin
            o_token.kind = KIND_END;
        end else if (i_character == CHAR_DOT) begin
            o_token.kind = KIND_DOT;
        end else if (i_character >= CHAR_ZERO && i_character <= CHAR_NINE) begin
            o_token.kind = KIND_DIGIT;
        end else begin
            o_token.kind = KIND_OTHER;
        end
    end

endmodule

/* design/dqip_fifo.sv */
// Two-entry token queue between the front end and the parse engine.
module dqip_fifo import dqip_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_token i_token,
    output logic   o_full,
    input  logic   i_rd,
    output logic   o_valid,
    output t_token o_token
);

    t_token     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_token = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr && !(i_rd && o_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_wr && i_rd && o_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_rd && o_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= 2'd2)
        else $error("token queue count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty token queue with pointers apart");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("full token queue with pointers apart");

endmodule

/* design/dqip_back.sv */
// Parse engine: field accumulation, dot counting, result formation and output slot.
module dqip_back import dqip_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tok_valid,
    input  t_token            i_tok,
    output logic              o_tok_take,
    input  logic              i_cfg_valid,
    input  logic              i_network_order,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [ADDR_W-1:0] o_address,
    output logic              o_valid_res
);

    logic               r_net_order;
    logic [FIELD_W-1:0] r_field, n_field;
    logic [DOTS_W-1:0]  r_dots,  n_dots;
    logic [ADDR_W-1:0]  r_part,  n_part;
    logic               r_err,   n_err;
    logic               r_out_full;
    logic [ADDR_W-1:0]  r_out_addr;
    logic               r_out_ok;

    logic [PROD_W-1:0]  prod;
    logic [ADDR_W-1:0]  closed;
    logic [ADDR_W-1:0]  shifted;
    logic [ADDR_W-1:0]  res_addr;
    logic               res_ok;
    logic               pop_ok;
    logic               end_take;

    assign pop_ok     = i_pop && r_out_full;
    assign o_tok_take = i_tok_valid && ((i_tok.kind != KIND_END) || !r_out_full || i_pop);
    assign end_take   = o_tok_take && (i_tok.kind == KIND_END);
    assign o_empty    = !r_out_full;
    assign o_address  = r_out_addr;
    assign o_valid_res = r_out_ok;

    assign prod   = {r_field, 3'b000} + {2'b00, r_field, 1'b0} + {8'b0, i_tok.digit};
    assign closed = {r_part[ADDR_W-9:0], r_field[7:0]};
    assign res_ok = !r_err && !r_field[8];

    always_comb begin
        unique case (r_dots)
            3'd0:    shifted = {closed[7:0], 24'b0};
            3'd1:    shifted = {closed[15:0], 16'b0};
            3'd2:    shifted = {closed[23:0], 8'b0};
            default: shifted = closed;
        endcase
        if (!res_ok) begin
            res_addr = '0;
        end else if (r_net_order) begin
            res_addr = byte_swap(shifted);
        end else begin
            res_addr = shifted;
        end
    end

    always_comb begin
        n_field = r_field;
        n_dots  = r_dots;
        n_part  = r_part;
        n_err   = r_err;
        if (o_tok_take) begin
            unique case (i_tok.kind)
                KIND_END: begin
                    n_field = '0;
                    n_dots  = '0;
                    n_part  = '0;
                    n_err   = 1'b0;
                end
                KIND_DIGIT: begin
                    if (!r_err) begin
                        n_field = (prod > {3'b0, FIELD_SAT}) ? FIELD_SAT : prod[FIELD_W-1:0];
                    end
                end
                KIND_DOT: begin
                    if (!r_err) begin
                        if (r_dots >= MAX_DOTS) begin
                            n_dots = DOTS_OVER;
                            n_err  = 1'b1;
                        end else begin
                            n_dots = r_dots + 3'd1;
                            if (r_field[8]) begin
                                n_err = 1'b1;
                            end else begin
                                n_part  = closed;
                                n_field = '0;
                            end
                        end
                    end
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_order <= 1'b0;
            r_field     <= '0;
            r_dots      <= '0;
            r_part      <= '0;
            r_err       <= 1'b0;
            r_out_full  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_net_order <= i_network_order;
            end
            r_field <= n_field;
            r_dots  <= n_dots;
            r_part  <= n_part;
            r_err   <= n_err;
            if (end_take) begin
                r_out_full <= 1'b1;
            end else if (pop_ok) begin
                r_out_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_take) begin
            r_out_addr <= res_addr;
            r_out_ok   <= res_ok;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_full && !r_out_ok) |-> (r_out_addr == '0))
        else $error("failed parse carries a non-zero address");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dots == DOTS_OVER) |-> r_err)
        else $error("fourth dot without error");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_dots <= DOTS_OVER)
        else $error("dot count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_take |=> (r_dots == '0 && r_field == '0 && !r_err && r_out_full))
        else $error("terminator did not clear the parse state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_full && !i_pop) |=> (r_out_full && $stable(r_out_addr) && $stable(r_out_ok)))
        else $error("unpopped result lost or changed");

endmodule

/* design/dotted_quad_ipv4_parser.sv */
// Top level of the dotted-quad IPv4 parser.
//  channel   | handshake                 | payload
//  input     | push / full               | i_character
//  result    | pop / empty               | o_address, o_valid_res
//  config    | i_cfg_valid / o_cfg_ready | i_network_order
// One character per cycle sustained while the engine does not stall. A request passes a two-entry
// token queue and is consumed from it by the parse engine; a NUL's result is loaded into the single
// output slot at the edge that consumes the NUL, from where it can be popped.
// The engine stalls only on a NUL while the slot is held and not popped; full rises once the
// queue holds that NUL and one request behind it. Synchronous active-low reset; no clearing pass.
module dotted_quad_ipv4_parser import dqip_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] i_character,
    output logic              empty,
    input  logic              pop,
    output logic [ADDR_W-1:0] o_address,
    output logic              o_valid_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_network_order
);

    logic   wr;
    t_token wr_token;
    logic   tok_valid;
    t_token tok;
    logic   tok_take;

    assign o_cfg_ready = 1'b1;

    dqip_front u_front (
        .i_push      (push),
        .i_full      (full),
        .i_character (i_character),
        .o_wr        (wr),
        .o_token     (wr_token)
    );

    dqip_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_token (wr_token),
        .o_full  (full),
        .i_rd    (tok_take),
        .o_valid (tok_valid),
        .o_token (tok)
    );

    dqip_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tok_valid     (tok_valid),
        .i_tok           (tok),
        .o_tok_take      (tok_take),
        .i_cfg_valid     (i_cfg_valid),
        .i_network_order (i_network_order),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_address       (o_address),
        .o_valid_res     (o_valid_res)
    );

endmodule

/* tb/tb_dotted_quad_ipv4_parser.sv */
// Self-checking testbench for the dotted-quad IPv4 parser: directed and random strings.
module tb_dotted_quad_ipv4_parser import dqip_pkg::*;;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              ok;
    } t_ipv4_expect;

    class ipv4_scoreboard;
        logic [FIELD_W-1:0] field_acc;
        logic [DOTS_W-1:0]  dots_seen;
        logic [ADDR_W-1:0]  addr_acc;
        bit                 bad;
        bit                 swap_bytes;
        t_ipv4_expect       pending[$];
        int                 fails;

        function new();
            swap_bytes = 1'b0;
            fails      = 0;
            clear();
        endfunction

        function void clear();
            field_acc = '0;
            dots_seen = '0;
            addr_acc  = '0;
            bad       = 1'b0;
        endfunction

        function void take_field();
            if (field_acc >= FIELD_SAT) begin
                bad = 1'b1;
            end else begin
                addr_acc  = {addr_acc[ADDR_W-9:0], field_acc[7:0]};
                field_acc = '0;
            end
        endfunction

        // one accepted character request
        function void note_char(logic [CHAR_W-1:0] c);
            t_ipv4_expect      e;
            logic [ADDR_W-1:0] host;
            int unsigned       acc;
            if (c == CHAR_NUL) begin
                e.address = '0;
                e.ok      = 1'b0;
                if (!bad) take_field();
                if (!bad) begin
                    host      = addr_acc << (8 * (MAX_DOTS - dots_seen));
                    e.address = host;
                    if (swap_bytes) begin
                        for (int i = 0; i < 4; i++) e.address[8*i +: 8] = host[8*(3-i) +: 8];
                    end
                    e.ok = 1'b1;
                end
                pending.insert(pending.size(), e);
                clear();
                return;
            end
            if (bad) return;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                acc       = int'(field_acc) * 10 + int'(c) - int'(CHAR_ZERO);
                field_acc = (acc > FIELD_SAT) ? FIELD_SAT : acc[FIELD_W-1:0];
            end else if (c == CHAR_DOT) begin
                if (dots_seen >= MAX_DOTS) begin
                    dots_seen = DOTS_OVER;
                    bad       = 1'b1;
                end else begin
                    dots_seen++;
                    take_field();
                end
            end else begin
                bad = 1'b1;
            end
        endfunction

        function void check_result(logic [ADDR_W-1:0] a, logic ok);
            t_ipv4_expect e;
            if (pending.size() == 0) begin
                fails++;
                $display("%0t: unexpected result, expected none, actual address %h valid %b",
                         $time, a, ok);
                return;
            end
            e = pending.pop_front();
            if (a !== e.address) begin
                fails++;
                $display("%0t: address expected %h actual %h", $time, e.address, a);
            end
            if (ok !== e.ok) begin
                fails++;
                $display("%0t: valid expected %b actual %b", $time, e.ok, ok);
            end
        endfunction
    endclass

    localparam int LIMIT = 600000;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [CHAR_W-1:0] i_character;
    logic              empty;
    logic              pop;
    logic [ADDR_W-1:0] o_address;
    logic              o_valid_res;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_network_order;

    ipv4_scoreboard    sb;
    logic [CHAR_W-1:0] line_buf[$];
    bit                calm;
    int                taken;
    int                popped;
    int                cfg_taken;
    int                cycles;

    dotted_quad_ipv4_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_character     (i_character),
        .empty           (empty),
        .pop             (pop),
        .o_address       (o_address),
        .o_valid_res     (o_valid_res),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_network_order (i_network_order)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("dotted_quad_ipv4_parser: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.swap_bytes = i_network_order;
                cfg_taken++;
            end
            if (push && !full) begin
                sb.note_char(i_character);
                taken++;
            end
            if (pop && !empty) begin
                sb.check_result(o_address, o_valid_res);
                popped++;
            end
        end
    end

    initial begin
        pop = 1'b0;
        wait (i_rst_n == 1'b1);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            pop = 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
        end
    end

    function automatic void put_char(logic [CHAR_W-1:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    function automatic void put_num(int unsigned v, int zeros);
        logic [CHAR_W-1:0] d[$];
        repeat (zeros) put_char(CHAR_ZERO);
        do begin
            d.push_front(8'(CHAR_ZERO + v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (d[i]) put_char(d[i]);
    endfunction

    function automatic void put_line(string s);
        foreach (s[i]) put_char(s[i]);
        put_char(CHAR_NUL);
    endfunction

    // n fields joined by dots; field big_at gets a value from 256 to 999 or a full random word
    function automatic void put_fields(int n, int big_at);
        int unsigned v;
        for (int i = 0; i < n; i++) begin
            if (i != 0) put_char(CHAR_DOT);
            if (i == big_at) begin
                put_num($urandom_range(0, 1) ? $urandom_range(256, 999) : $urandom, 0);
            end else if ($urandom_range(0, 9) != 0) begin
                case ($urandom_range(0, 3))
                    0:       v = 0;
                    1:       v = 255;
                    default: v = $urandom_range(0, 255);
                endcase
                put_num(v, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
            end
        end
    endfunction

    // called at a falling edge; returns at the falling edge after the last request
    task automatic send_line(bit gappy);
        int seen;
        foreach (line_buf[i]) begin
            if (gappy && $urandom_range(0, 3) == 0) begin
                push = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            push        = 1'b1;
            i_character = line_buf[i];
            seen        = taken;
            do @(negedge i_clk); while (taken == seen);
        end
        line_buf.delete();
    endtask

    task automatic drain();
        push = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_order(bit v);
        int seen;
        seen            = cfg_taken;
        i_cfg_valid     = 1'b1;
        i_network_order = v;
        do @(negedge i_clk); while (cfg_taken == seen);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_random(int target);
        int                n;
        int                pos;
        logic [CHAR_W-1:0] c;
        while (taken < target) begin
            case ($urandom_range(0, 9))
                7: begin
                    n = $urandom_range(1, 4);
                    put_fields(n, $urandom_range(0, n - 1));
                end
                8: begin
                    case ($urandom_range(0, 1))
                        0: put_fields($urandom_range(5, 6), -1);
                        default: begin
                            put_fields($urandom_range(1, 4), -1);
                            do c = 8'($urandom_range(1, 255));
                            while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_DOT);
                            pos = $urandom_range(0, line_buf.size());
                            line_buf.insert(pos, c);
                        end
                    endcase
                end
                9: begin
                    repeat ($urandom_range(1, 8)) put_char(8'($urandom_range(1, 255)));
                end
                default: begin
                    n = $urandom_range(1, 4);
                    put_fields(n, -1);
                    if (n < 4 && $urandom_range(0, 5) == 0) put_char(CHAR_DOT);
                end
            endcase
            put_char(CHAR_NUL);
            send_line(!calm && $urandom_range(0, 2) != 0);
            if ($urandom_range(0, 29) == 0) drain();
        end
    endtask

    initial begin
        sb              = new();
        i_rst_n         = 1'b0;
        push            = 1'b0;
        i_character     = CHAR_NUL;
        i_cfg_valid     = 1'b0;
        i_network_order = 1'b0;
        calm            = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_order(1'b0);
        put_char(CHAR_NUL);
        put_line("255.0.9.1");
        put_line("256");
        put_line("....");
        put_char(8'hFF);
        put_line("5");
        put_line("3.");
        send_line(1'b1);
        drain();

        write_order(1'b1);
        run_random(taken + 500);
        drain();
        write_order(1'b0);
        run_random(taken + 500);
        drain();
        write_order(1'b1);
        calm = 1'b1;
        run_random(taken + 550);
        drain();

        $display("%0d characters sent, %0d addresses checked in both byte orders", taken, popped);
        $display("with random stalls on both sides and a stall-free final stretch");
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("dotted_quad_ipv4_parser: match");
        end else begin
            $display("dotted_quad_ipv4_parser: mismatch");
        end
        $finish;
    end

endmodule
